// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the output sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- hw/rtl/mtr_pkg.sv -----
// types and constants of the modbus tcp to rtu request converter
package mtr_pkg;

  localparam int COUNT_W = 9;
  localparam int HDR_BYTES = 6;
  localparam int LEN_HI_IDX = 4;
  localparam int LEN_LO_IDX = 5;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_TOO_MUCH = 2'd1;
  localparam logic [1:0] STATUS_BUF_FULL = 2'd2;

  // what one taken byte turns into
  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // output word position within one record
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_CRC_LO = 2'd1;
  localparam logic [1:0] PH_CRC_HI = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] crc;
    logic [1:0]  status;
  } result_t;

endpackage

// ----- hw/rtl/mtr_parser.sv -----
// frame parser: mbap header, length check, crc update
module mtr_parser #(
  parameter int FRAME_BYTES = 260
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       data,
  input  logic             take,
  output mtr_pkg::result_t res
);
  import mtr_pkg::*;

  localparam logic [COUNT_W:0] FRAME_LIM = (COUNT_W+1)'(FRAME_BYTES);

  logic [COUNT_W-1:0] count, count_next;
  logic [15:0]        length, length_next;
  logic [15:0]        crc, crc_next;
  logic [COUNT_W:0]   n;
  logic [16:0]        target;
  logic [15:0]        crc_upd;

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  always_comb begin
    n = {1'b0, count} + 1'b1;
    target = {1'b0, length} + 17'(HDR_BYTES);
    crc_upd = crc_update(crc, data);
    count_next = count;
    length_next = length;
    crc_next = crc;
    res = '0;
    res.kind = KIND_PASS;
    res.status = STATUS_OK;
    priority if (count < COUNT_W'(HDR_BYTES)) begin
      if (count == COUNT_W'(LEN_HI_IDX)) length_next = {data, 8'h00};
      else if (count == COUNT_W'(LEN_LO_IDX)) length_next = {length[15:8], data};
      if (n >= FRAME_LIM) begin
        res.valid = 1'b1;
        res.kind = KIND_ERR;
        res.status = STATUS_BUF_FULL;
        count_next = '0;
        length_next = '0;
        crc_next = CRC_INIT;
      end else begin
        count_next = n[COUNT_W-1:0];
      end
    end else if (17'(n) > target) begin
      res.valid = 1'b1;
      res.kind = KIND_ERR;
      res.status = STATUS_TOO_MUCH;
      count_next = '0;
      length_next = '0;
      crc_next = CRC_INIT;
    end else if (17'(n) == target) begin
      res.valid = 1'b1;
      res.kind = KIND_DONE;
      res.data = data;
      res.crc = crc_upd;
      count_next = '0;
      length_next = '0;
      crc_next = CRC_INIT;
    end else if (n >= FRAME_LIM) begin
      res.valid = 1'b1;
      res.kind = KIND_ERR;
      res.status = STATUS_BUF_FULL;
      count_next = '0;
      length_next = '0;
      crc_next = CRC_INIT;
    end else begin
      res.valid = 1'b1;
      res.data = data;
      crc_next = crc_upd;
      count_next = n[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      length <= '0;
      crc <= CRC_INIT;
    end else if (take) begin
      count <= count_next;
      length <= length_next;
      crc <= crc_next;
    end
  end

endmodule

// ----- hw/rtl/mtr_out_seq.sv -----
// output sequencer: one or three words per record
`include "assert_macros.svh"
module mtr_out_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  mtr_pkg::result_t res,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             frame_end,
  output logic [1:0]       status
);
  import mtr_pkg::*;

  logic        rec_valid;
  logic [1:0]  phase;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic [15:0] crc;
  logic [1:0]  err_status;
  logic        last;
  logic        fire;

  assign last = (kind != KIND_DONE) || (phase == PH_CRC_HI);
  assign fire = rec_valid && !out_stall;
  assign ready = !rec_valid || (last && !out_stall);
  assign out_valid = rec_valid;

  always_comb begin
    unique case (phase)
      PH_DATA: begin
        out_byte = (kind == KIND_ERR) ? 8'h00 : data;
        frame_end = (kind == KIND_ERR);
        status = (kind == KIND_ERR) ? err_status : STATUS_OK;
      end
      PH_CRC_LO: begin
        out_byte = crc[7:0];
        frame_end = 1'b0;
        status = STATUS_OK;
      end
      PH_CRC_HI: begin
        out_byte = crc[15:8];
        frame_end = 1'b1;
        status = STATUS_OK;
      end
      default: begin
        out_byte = 8'h00;
        frame_end = 1'b0;
        status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      phase <= PH_DATA;
    end else if (load) begin
      rec_valid <= 1'b1;
      phase <= PH_DATA;
    end else if (fire) begin
      if (last) begin
        rec_valid <= 1'b0;
        phase <= PH_DATA;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind <= res.kind;
      data <= res.data;
      crc <= res.crc;
      err_status <= res.status;
    end
  end

  `ASSERT_NEVER(a_crc_phase_kind, clk, rst, rec_valid && (phase != PH_DATA) && (kind != KIND_DONE),
                "crc phase on a record without crc")
  `ASSERT_NEVER(a_load_overrun, clk, rst, load && rec_valid && !(last && !out_stall),
                "record overwritten before its last word left")
  `ASSERT_PROP(a_crc_hi_follows, clk, rst,
               fire && (phase == PH_CRC_LO) |=> rec_valid && (phase == PH_CRC_HI),
               "crc high word did not follow crc low word")

endmodule

// ----- hw/rtl/modbus_tcp_to_rtu_request_converter.sv -----
// top level of the modbus tcp to rtu request converter
// Takes a Modbus TCP request one byte word per cycle and streams out the RTU
// frame: the six MBAP header bytes are dropped (bytes 4 and 5 give the length),
// the unit id and PDU pass through while a CRC-16/MODBUS runs over them, and
// the CRC follows low byte then high byte, the high byte marked frame_end. A
// zero length gives one error word (status 1), a frame reaching FRAME_BYTES
// gives one error word (status 2); the receiver drops a partial frame on
// error. Rate is one input word per cycle while out_stall is low; a completed
// frame adds its CRC words from the single output sequencer, during which
// input stalls once its input register is full. An input word passes the
// input register, then the sequencer's record register, on its way out.
module modbus_tcp_to_rtu_request_converter #(
  parameter int FRAME_BYTES = 260
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic [1:0] status
);
  import mtr_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  result_t res;
  logic    seq_ready;
  logic    take;

  // header words need no output slot, everything else waits for the sequencer
  assign take = in_valid_q && (!res.valid || seq_ready);
  assign in_stall = in_valid_q && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_q <= in_byte;
    end
  end

  // header parse, length check and crc
  mtr_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .data (in_byte_q),
    .take (take),
    .res  (res)
  );

  // result record, emits data or error word, then crc words on completion
  mtr_out_seq u_out_seq (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res.valid),
    .res       (res),
    .ready     (seq_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .status    (status)
  );

endmodule

// ----- bench/modbus_tcp_to_rtu_request_converter_tb.sv -----
// testbench for the modbus tcp to rtu request converter: random and directed requests
module modbus_tcp_to_rtu_request_converter_tb;
  import mtr_pkg::*;

  localparam int FRAME_LEN = 260;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_WORDS = 6;    // per idling phase, four phases

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       frame_end;
  logic [1:0] status;

  modbus_tcp_to_rtu_request_converter #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .frame_end(frame_end),
    .status   (status)
  );

  // one rtu output word as the converter should produce it
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [1:0] st;
  } rtu_word_t;

  rtu_word_t rtu_word_q[$];

  // shadow of the converter state
  int unsigned frame_pos;
  logic [15:0] shadow_len;
  logic [15:0] crc_run;

  // idling knobs, percent per cycle
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // long receiver hold-off, requested by toggling hold_tog
  logic        hold_tog;
  logic        hold_seen;
  int unsigned hold_left;

  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned words_sent;
  int unsigned frames_done;
  int unsigned too_much_seen;
  int unsigned buf_full_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: crc-16/modbus, reflected poly, one byte at a time
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic void restart_frame();
    frame_pos  = 0;
    shadow_len = 16'h0000;
    crc_run    = CRC_INIT;
  endfunction

  function automatic void push_rtu_word(input logic [7:0] d, input logic last,
                                        input logic [1:0] st);
    rtu_word_t w;
    w.data = d;
    w.last = last;
    w.st   = st;
    rtu_word_q.push_back(w);
  endfunction

  // work out the rtu words caused by one accepted tcp byte
  function automatic void convert_tcp_byte(input logic [7:0] b);
    int unsigned next_pos;
    int unsigned frame_target;
    logic [15:0] crc_new;
    // mbap header: only the length bytes matter, nothing comes out
    if (frame_pos < HDR_BYTES) begin
      if (frame_pos == LEN_HI_IDX) begin
        shadow_len = {b, 8'h00};
      end else if (frame_pos == LEN_LO_IDX) begin
        shadow_len[7:0] = b;
      end
      frame_pos++;
      if (frame_pos >= FRAME_LEN) begin
        restart_frame();
        push_rtu_word(8'h00, 1'b1, STATUS_BUF_FULL);
      end
      return;
    end
    next_pos     = frame_pos + 1;
    frame_target = shadow_len + HDR_BYTES;
    // only a zero length can put us past the target
    if (next_pos > frame_target) begin
      restart_frame();
      push_rtu_word(8'h00, 1'b1, STATUS_TOO_MUCH);
      return;
    end
    // last byte of the pdu: byte, crc low, crc high with the end mark
    if (next_pos == frame_target) begin
      crc_new = crc16_modbus_byte(crc_run, b);
      push_rtu_word(b, 1'b0, STATUS_OK);
      push_rtu_word(crc_new[7:0], 1'b0, STATUS_OK);
      push_rtu_word(crc_new[15:8], 1'b1, STATUS_OK);
      restart_frame();
      return;
    end
    // completion wins over buffer full, so this only hits an unfinished frame
    if (next_pos >= FRAME_LEN) begin
      restart_frame();
      push_rtu_word(8'h00, 1'b1, STATUS_BUF_FULL);
      return;
    end
    crc_run   = crc16_modbus_byte(crc_run, b);
    frame_pos = next_pos;
    push_rtu_word(b, 1'b0, STATUS_OK);
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // offer one tcp byte, optionally after random idle cycles, and predict on accept.
  // valid is left high after the accept so back-to-back words need no re-raise
  task automatic push_tcp_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    convert_tcp_byte(b);
    words_sent++;
  endtask

  task automatic quiet_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one modbus tcp request: random transaction and protocol id, given length,
  // then unit id and pdu. a zero length gets one trailing byte to trip the error,
  // an oversized one is cut where the buffer runs full
  task automatic send_request(input logic [15:0] len);
    int unsigned body;
    push_tcp_byte(8'($urandom_range(255)));
    push_tcp_byte(8'($urandom_range(255)));
    push_tcp_byte(8'($urandom_range(255)));
    push_tcp_byte(8'($urandom_range(255)));
    push_tcp_byte(len[15:8]);
    push_tcp_byte(len[7:0]);
    if (len == 16'd0) begin
      body = 1;
    end else if (len > FRAME_LEN - HDR_BYTES) begin
      body = FRAME_LEN - HDR_BYTES;
    end else begin
      body = len;
    end
    for (int i = 0; i < body; i++) push_tcp_byte(8'($urandom_range(255)));
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) push_tcp_byte(bytes[i]);
  endtask

  task automatic wait_drained();
    while (rtu_word_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall, or a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // compare every accepted output word with the oldest prediction
  always @(posedge clk) begin
    rtu_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (rtu_word_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: byte %02h end %0b status %0d", out_byte, frame_end,
                   status);
        end
      end else begin
        w = rtu_word_q.pop_front();
        if (out_byte !== w.data || frame_end !== w.last || status !== w.st) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word mismatch: exp %02h/%0b/%0d, got %02h/%0b/%0d (byte/end/status)",
                     w.data, w.last, w.st, out_byte, frame_end, status);
          end
        end
        if (w.last && w.st == STATUS_OK) frames_done++;
        if (w.st == STATUS_TOO_MUCH) too_much_seen++;
        if (w.st == STATUS_BUF_FULL) buf_full_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt,
               rtu_word_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // read holding registers, zero length, length one, extremes of the bytes
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // well-formed request, length 6, all-ones transaction id
    send_bytes('{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h06,
                 8'h11, 8'h03, 8'h00, 8'h6B, 8'h00, 8'h03});
    // zero length: first byte after the header turns into an error word
    send_bytes('{8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hA5});
    // length one: unit id alone completes the frame at once
    send_bytes('{8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF});
    quiet_sender();
    wait_drained();
  endtask

  // frame one byte too long for the buffer, cut where it runs full
  task automatic test_buffer_limits();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    send_request(16'(FRAME_LEN - HDR_BYTES + 1));
    quiet_sender();
    wait_drained();
  endtask

  // receiver holds off while the sender streams, then the receiver drains
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_tog <= ~hold_tog;
    send_request(16'd8);
    quiet_sender();
    wait_drained();
  endtask

  // mostly short well-formed requests, some zero-length ones mixed in
  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned start_cnt;
    int unsigned pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_cnt = words_sent;
    while (words_sent - start_cnt < RANDOM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_request(16'd0);
      end else if (pick < 20) begin
        send_request(16'($urandom_range(40, 13)));
      end else begin
        send_request(16'($urandom_range(12, 1)));
      end
    end
    quiet_sender();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    out_stall      = 1'b0;
    hold_tog       = 1'b0;
    hold_seen      = 1'b0;
    hold_left      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    cycle_cnt      = 0;
    words_sent     = 0;
    frames_done    = 0;
    too_much_seen  = 0;
    buf_full_seen  = 0;
    restart_frame();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_buffer_limits();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(46, 0);
    test_random_phase(0, 46);
    test_random_phase(36, 36);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d tcp words: %0d rtu frames completed, %0d zero-length errors,",
             words_sent, frames_done, too_much_seen);
    $display("%0d buffer overruns, with sender gaps, receiver stalls and a long hold-off",
             buf_full_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatching words", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mtr_pkg.sv
hw/rtl/mtr_parser.sv
hw/rtl/mtr_out_seq.sv
hw/rtl/modbus_tcp_to_rtu_request_converter.sv
bench/modbus_tcp_to_rtu_request_converter_tb.sv
